[sv/fcts_pkg.sv]
// Shared types and constants for the floppy CHS transfer splitter.
package fcts_pkg;

	localparam logic [7:0] OP_READ  = 8'hE6;
	localparam logic [7:0] OP_WRITE = 8'hC5;

	localparam int MAX_SECTORS_DEF = 64;

	localparam logic [5:0]  SPT_RST   = 6'd18;
	localparam logic [1:0]  HEADS_RST = 2'd2;
	localparam logic [7:0]  CYL_RST   = 8'd80;
	localparam logic [10:0] SBYTE_RST = 11'd512;

	typedef enum logic [7:0] {
		CFG_SPT   = 8'd0,
		CFG_HEADS = 8'd1,
		CFG_CYL   = 8'd2,
		CFG_SBYTE = 8'd3
	} cfg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_HEAD,
		ST_EMIT
	} st_t;

endpackage

[sv/floppy_chs_transfer_splitter.sv]
// Floppy CHS transfer splitter: LBA to CHS conversion and per-cylinder chunking.
//
// Usage: pulse start with req_type, drive, lba and sector_total while busy is
// low; the request is taken at that edge. The block converts the logical sector to track,
// head and one-based sector, then emits one result per chunk so that no chunk crosses a
// cylinder. Each result sits on the result ports for one cycle, marked by result_valid;
// the receiver cannot stall, so nothing here waits on it. The result with last set ends
// the request; an out-of-range track gives a result with bad_address and last set.
// Sequence: an empty request or a zero geometry answers in the cycle after the start edge.
// Otherwise a 16-step restoring divide by sectors-per-cylinder runs (one quotient bit a
// cycle through one compare/subtract), then head compare/subtract steps peel whole tracks
// off the in-cylinder offset, then the chunks follow at one chunk a cycle. busy drops at
// the edge that puts the final result on the ports.
// Configuration: the write channel (cfg_valid/cfg_ready, cfg_index, cfg_data) is always
// ready; write registers only while busy is low and no result is pending.
// Reset: arst_n clears the sequencer and loads the default geometry (18 sectors,
// 2 heads, 80 cylinders, 512-byte sectors).
module floppy_chs_transfer_splitter #(
	parameter int MAX_SECTORS = fcts_pkg::MAX_SECTORS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// request channel
	input  logic        start,
	output logic        busy,
	input  logic        req_type,
	input  logic [1:0]  drive,
	input  logic [15:0] lba,
	input  logic [6:0]  sector_total,
	// configuration channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_index,
	input  logic [10:0] cfg_data,
	// result channel
	output logic        result_valid,
	output logic [7:0]  opcode,
	output logic [2:0]  drive_head_byte,
	output logic [7:0]  track,
	output logic        head,
	output logic [5:0]  sector,
	output logic [6:0]  chunk_sectors,
	output logic [16:0] byte_count,
	output logic        bad_address,
	output logic        last
);

	// geometry registers
	logic [5:0]  spt_q;
	logic [1:0]  heads_q;
	logic [7:0]  cyl_q;
	logic [10:0] sbyte_q;

	// sequencer
	fcts_pkg::st_t st_q, st_nxt;

	// working request state
	logic [7:0]  opc_q;
	logic [1:0]  drv_q;
	logic [6:0]  left_q;     // sectors still to issue
	logic [7:0]  spc_q;      // sectors per cylinder
	logic [15:0] dvd_q;      // dividend, shifts into quotient
	logic [7:0]  rem_q;      // division remainder, then sector index within track
	logic [3:0]  cnt_q;      // divide step counter
	logic [7:0]  trk_q;      // current track, saturated at 255
	logic [1:0]  hd_q;       // current head
	logic [7:0]  avail_q;    // sectors left in the current cylinder

	logic req_acc;
	logic cfg_acc;
	logic [6:0] total_clamp;
	logic geom_zero;

	// compare/subtract signals for the divide and head steps
	logic [8:0]  trial;
	logic        div_ge;
	logic [7:0]  rem_nxt;
	logic [15:0] quot;
	logic        head_ge;

	// chunk emit signals
	logic [6:0]  chunk_c;
	logic [17:0] prod_c;
	logic [6:0]  remain_c;
	logic        trk_bad;

	assign req_acc = start && !busy;
	assign cfg_acc = cfg_valid && cfg_ready;

	assign total_clamp = (32'(sector_total) > MAX_SECTORS) ? 7'(MAX_SECTORS) : sector_total;
	assign geom_zero   = (spt_q == 6'd0) || (heads_q == 2'd0);

	// divide step: shift in next dividend bit, subtract if it fits
	assign trial   = {rem_q, dvd_q[15]};
	assign div_ge  = trial >= {1'b0, spc_q};
	assign rem_nxt = div_ge ? 8'(trial - {1'b0, spc_q}) : trial[7:0];
	assign quot    = {dvd_q[14:0], div_ge};

	// head step: peel off whole tracks from the in-cylinder offset
	assign head_ge = rem_q >= {2'b00, spt_q};

	// chunk sizing: stop at the cylinder boundary
	assign chunk_c  = ({1'b0, left_q} > avail_q) ? avail_q[6:0] : left_q;
	assign prod_c   = 18'(chunk_c) * 18'(sbyte_q);
	assign remain_c = left_q - chunk_c;
	assign trk_bad  = trk_q >= cyl_q;

	// next-state logic
	always_comb begin
		st_nxt = st_q;
		case (st_q)
			fcts_pkg::ST_IDLE: begin
				if (req_acc && total_clamp != 7'd0 && !geom_zero) begin
					st_nxt = fcts_pkg::ST_DIV;
				end
			end
			fcts_pkg::ST_DIV: begin
				if (cnt_q == 4'd0) begin
					st_nxt = fcts_pkg::ST_HEAD;
				end
			end
			fcts_pkg::ST_HEAD: begin
				if (!head_ge) begin
					st_nxt = fcts_pkg::ST_EMIT;
				end
			end
			fcts_pkg::ST_EMIT: begin
				if (trk_bad || remain_c == 7'd0) begin
					st_nxt = fcts_pkg::ST_IDLE;
				end
			end
			default: st_nxt = fcts_pkg::ST_IDLE;
		endcase
	end

	// handshake outputs
	always_comb begin
		busy      = (st_q != fcts_pkg::ST_IDLE);
		cfg_ready = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= fcts_pkg::ST_IDLE;
		end else begin
			st_q <= st_nxt;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spt_q   <= fcts_pkg::SPT_RST;
			heads_q <= fcts_pkg::HEADS_RST;
			cyl_q   <= fcts_pkg::CYL_RST;
			sbyte_q <= fcts_pkg::SBYTE_RST;
		end else if (cfg_acc) begin
			case (cfg_index)
				fcts_pkg::CFG_SPT:   spt_q   <= cfg_data[5:0];
				fcts_pkg::CFG_HEADS: heads_q <= cfg_data[1:0];
				fcts_pkg::CFG_CYL:   cyl_q   <= cfg_data[7:0];
				fcts_pkg::CFG_SBYTE: sbyte_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else begin
			result_valid <= (st_q == fcts_pkg::ST_IDLE && req_acc &&
			                 (total_clamp == 7'd0 || geom_zero)) ||
			                (st_q == fcts_pkg::ST_EMIT);
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (st_q)
			fcts_pkg::ST_IDLE: begin
				if (req_acc) begin
					opc_q  <= req_type ? fcts_pkg::OP_WRITE : fcts_pkg::OP_READ;
					drv_q  <= drive;
					left_q <= total_clamp;
					spc_q  <= {2'b00, spt_q} * {6'd0, heads_q};
					dvd_q  <= lba;
					rem_q  <= 8'd0;
					cnt_q  <= 4'd15;
					hd_q   <= 2'd0;
					// empty request and zero geometry answer at once
					opcode          <= 8'd0;
					drive_head_byte <= 3'd0;
					track           <= 8'd0;
					head            <= 1'b0;
					sector          <= 6'd0;
					chunk_sectors   <= 7'd0;
					byte_count      <= 17'd0;
					bad_address     <= (total_clamp != 7'd0);
					last            <= 1'b1;
				end
			end
			fcts_pkg::ST_DIV: begin
				dvd_q <= quot;
				rem_q <= rem_nxt;
				cnt_q <= cnt_q - 4'd1;
				if (cnt_q == 4'd0) begin
					trk_q   <= (|quot[15:8]) ? 8'hFF : quot[7:0];
					avail_q <= spc_q - rem_nxt;
				end
			end
			fcts_pkg::ST_HEAD: begin
				if (head_ge) begin
					rem_q <= rem_q - {2'b00, spt_q};
					hd_q  <= hd_q + 2'd1;
				end
			end
			fcts_pkg::ST_EMIT: begin
				track  <= trk_q;
				head   <= hd_q[0];
				sector <= 6'(rem_q + 8'd1);
				if (trk_bad) begin
					opcode          <= 8'd0;
					drive_head_byte <= 3'd0;
					chunk_sectors   <= 7'd0;
					byte_count      <= 17'd0;
					bad_address     <= 1'b1;
					last            <= 1'b1;
				end else begin
					opcode          <= opc_q;
					drive_head_byte <= {hd_q[0], drv_q};
					chunk_sectors   <= chunk_c;
					byte_count      <= prod_c[17] ? 17'h1FFFF : prod_c[16:0];
					bad_address     <= 1'b0;
					last            <= (remain_c == 7'd0);
					// advance to the start of the next cylinder
					left_q  <= remain_c;
					trk_q   <= trk_q + 8'd1;
					hd_q    <= 2'd0;
					rem_q   <= 8'd0;
					avail_q <= spc_q;
				end
			end
			default: ;
		endcase
	end

	// an error result always closes the request
	a_bad_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && bad_address |-> last)
		else $error("error result without last");

	// more chunks pending means the sequencer is still running
	a_notlast_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !last |-> busy)
		else $error("non-final result while idle");

	// a command chunk always moves at least one sector
	a_cmd_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && opcode != 8'd0 |-> chunk_sectors != 7'd0 && !bad_address)
		else $error("command result with empty chunk");

	// an accepted request with a nonzero count makes the block busy or answers in the next cycle
	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && sector_total != 7'd0 && !result_valid |=>
		busy || result_valid)
		else $error("request dropped");

endmodule

[tb/fcts_result_monitor.sv]
// Request/result monitor for the floppy CHS transfer splitter: predicts chunks and compares.
`timescale 1ns / 100ps
module fcts_result_monitor (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic        req_type,
	input  logic [1:0]  drive,
	input  logic [15:0] lba,
	input  logic [6:0]  sector_total,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [7:0]  cfg_index,
	input  logic [10:0] cfg_data,
	input  logic        result_valid,
	input  logic [7:0]  opcode,
	input  logic [2:0]  drive_head_byte,
	input  logic [7:0]  track,
	input  logic        head,
	input  logic [5:0]  sector,
	input  logic [6:0]  chunk_sectors,
	input  logic [16:0] byte_count,
	input  logic        bad_address,
	input  logic        last,
	output int          mismatches,
	output int          pending
);

	typedef struct packed {
		logic [7:0]  opcode;
		logic [2:0]  drive_head;
		logic [7:0]  track;
		logic        head;
		logic [5:0]  sector;
		logic [6:0]  count;
		logic [16:0] bytes;
		logic        bad;
		logic        last;
	} chunk_cmd_t;

	chunk_cmd_t  pending_chunks[$];
	logic [5:0]  spt_reg;
	logic [1:0]  heads_reg;
	logic [7:0]  cyl_reg;
	logic [10:0] sbytes_reg;

	task automatic report_mismatch(string what);
		$display("%0t ns: mismatch: %s", $time, what);
		mismatches++;
	endtask

	task automatic check_field(string name, int unsigned got, int unsigned want);
		if (got != want)
			report_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
	endtask

	// Convert one request to CHS and cut it at cylinder ends, queueing each chunk.
	function automatic void split_request(logic rw, logic [1:0] drv, logic [15:0] first,
			logic [6:0] total);
		int unsigned lsec, left, spc, hd, trk, sec, len, used, bytes, n;
		chunk_cmd_t  cmd;
		lsec = 32'(first);
		left = 32'(total);
		if (left > 32'(fcts_pkg::MAX_SECTORS_DEF))
			left = 32'(fcts_pkg::MAX_SECTORS_DEF);
		spc = 32'(spt_reg) * 32'(heads_reg);
		cmd = '0;
		cmd.last = 1'b1;
		if (left == 0) begin
			pending_chunks.push_back(cmd);
			return;
		end
		if (spt_reg == 6'd0 || heads_reg == 2'd0) begin
			cmd.bad = 1'b1;
			pending_chunks.push_back(cmd);
			return;
		end
		n = 0;
		while (left > 0 && n < 32'(fcts_pkg::MAX_SECTORS_DEF)) begin
			hd  = (lsec % spc) / 32'(spt_reg);
			trk = lsec / spc;
			sec = (lsec % 32'(spt_reg)) + 1;
			cmd = '0;
			cmd.head = hd[0];
			cmd.sector = sec[5:0];
			if (trk >= 32'(cyl_reg)) begin
				cmd.track = (trk > 255) ? 8'hFF : trk[7:0];
				cmd.bad = 1'b1;
				cmd.last = 1'b1;
				pending_chunks.push_back(cmd);
				return;
			end
			used = hd * 32'(spt_reg) + sec - 1;
			len = left;
			if (used + len > spc)
				len = spc - used;
			bytes = len * 32'(sbytes_reg);
			if (bytes > 32'h1FFFF)
				bytes = 32'h1FFFF;
			left -= len;
			lsec += len;
			cmd.opcode = rw ? fcts_pkg::OP_WRITE : fcts_pkg::OP_READ;
			cmd.drive_head = {hd[0], drv};
			cmd.track = trk[7:0];
			cmd.count = len[6:0];
			cmd.bytes = bytes[16:0];
			cmd.last = (left == 0);
			pending_chunks.push_back(cmd);
			n++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		chunk_cmd_t want;
		if (!arst_n) begin
			pending_chunks.delete();
			spt_reg <= fcts_pkg::SPT_RST;
			heads_reg <= fcts_pkg::HEADS_RST;
			cyl_reg <= fcts_pkg::CYL_RST;
			sbytes_reg <= fcts_pkg::SBYTE_RST;
		end else begin
			if (result_valid) begin
				if (pending_chunks.size() == 0) begin
					report_mismatch($sformatf("unexpected result track 0x%0h sector 0x%0h",
						track, sector));
				end else begin
					want = pending_chunks.pop_front();
					check_field("opcode", 32'(opcode), 32'(want.opcode));
					check_field("drive_head_byte", 32'(drive_head_byte),
						32'(want.drive_head));
					check_field("track", 32'(track), 32'(want.track));
					check_field("head", 32'(head), 32'(want.head));
					check_field("sector", 32'(sector), 32'(want.sector));
					check_field("chunk_sectors", 32'(chunk_sectors), 32'(want.count));
					check_field("byte_count", 32'(byte_count), 32'(want.bytes));
					check_field("bad_address", 32'(bad_address), 32'(want.bad));
					check_field("last", 32'(last), 32'(want.last));
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					fcts_pkg::CFG_SPT: spt_reg <= cfg_data[5:0];
					fcts_pkg::CFG_HEADS: heads_reg <= cfg_data[1:0];
					fcts_pkg::CFG_CYL: cyl_reg <= cfg_data[7:0];
					fcts_pkg::CFG_SBYTE: sbytes_reg <= cfg_data;
					default: ;
				endcase
			end
			// A request taken at this edge still sees the geometry held before it.
			if (start && !busy)
				split_request(req_type, drive, lba, sector_total);
		end
		pending = pending_chunks.size();
	end

endmodule

[tb/tb.sv]
// Top of the floppy CHS transfer splitter testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module tb;

	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_CYCLES = 25;   // divide plus head steps plus a margin
	localparam int PHASE_ITEMS = 16;
	localparam int PHASES = 9;
	localparam logic [7:0] CFG_UNMAPPED = 8'd9;   // index with no register behind it

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic        req_type = 1'b0;
	logic [1:0]  drive = '0;
	logic [15:0] lba = '0;
	logic [6:0]  sector_total = '0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [7:0]  cfg_index = '0;
	logic [10:0] cfg_data = '0;
	logic        result_valid;
	logic [7:0]  opcode;
	logic [2:0]  drive_head_byte;
	logic [7:0]  track;
	logic        head;
	logic [5:0]  sector;
	logic [6:0]  chunk_sectors;
	logic [16:0] byte_count;
	logic        bad_address;
	logic        last;
	int          mismatches;
	int          pending;
	int          cycles = 0;

	// Geometry in force, used only to aim random requests at the disk.
	int unsigned spt_now = 32'(fcts_pkg::SPT_RST);
	int unsigned heads_now = 32'(fcts_pkg::HEADS_RST);
	int unsigned cyl_now = 32'(fcts_pkg::CYL_RST);

	floppy_chs_transfer_splitter DUT (.*);
	fcts_result_monitor result_monitor (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Watchdog: a hung request or a missing last result ends the run here.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end
	end

	// Present one request after a random gap and hold it until busy is low at an edge.
	// Start stays high straight into the next request when that one draws no gap.
	task automatic send_request(logic rw, logic [1:0] drv, logic [15:0] lsec,
			logic [6:0] total);
		int gap;
		gap = $urandom_range(0, 4);
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		req_type <= rw;
		drive <= drv;
		lba <= lsec;
		sector_total <= total;
		do @(posedge clk); while (busy);
	endtask

	// Drop start, then hold until every chunk is back and the block is idle.
	// Sample at the falling edge so the monitor's count has settled.
	task automatic wait_idle();
		start <= 1'b0;
		do @(negedge clk); while (pending != 0 || busy);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [7:0] idx, logic [10:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// Load all four registers back to back from raw write data; the block keeps low bits.
	task automatic set_geometry(logic [10:0] spt, logic [10:0] heads, logic [10:0] cyl,
			logic [10:0] sbytes);
		write_reg(fcts_pkg::CFG_SPT, spt);
		write_reg(fcts_pkg::CFG_HEADS, heads);
		write_reg(fcts_pkg::CFG_CYL, cyl);
		write_reg(fcts_pkg::CFG_SBYTE, sbytes);
		cfg_valid <= 1'b0;
		spt_now = 32'(spt[5:0]);
		heads_now = 32'(heads[1:0]);
		cyl_now = 32'(cyl[7:0]);
	endtask

	// Mostly requests that land on the disk or run just past its end, with random
	// counts; the rest spread over the whole logical sector range.
	task automatic random_request();
		int unsigned spc, hi, lsec, total, pick;
		spc = spt_now * heads_now;
		hi = spc * cyl_now + spc;
		if (hi > 65535)
			hi = 65535;
		if ($urandom_range(0, 9) < 7 && spc != 0)
			lsec = $urandom_range(0, hi);
		else
			lsec = $urandom_range(0, 65535);
		pick = $urandom_range(0, 9);
		if (pick == 0)
			total = 0;
		else if (pick == 1)
			total = $urandom_range(65, 127);
		else
			total = $urandom_range(1, 64);
		send_request(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)), 16'(lsec),
			7'(total));
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed requests on the reset geometry: 18 sectors, 2 heads, 80 cylinders,
		// so one cylinder holds 36 sectors and the disk ends at sector 2879.
		send_request(1'b0, 2'd0, 16'd0, 7'd1);        // first sector of the disk
		send_request(1'b1, 2'd3, 16'd0, 7'd0);        // empty request
		send_request(1'b0, 2'd1, 16'd0, 7'd36);       // exactly one cylinder
		send_request(1'b1, 2'd2, 16'd17, 7'd2);       // head change inside a cylinder
		send_request(1'b0, 2'd0, 16'd18, 7'd1);       // head 1 into the select byte
		send_request(1'b1, 2'd1, 16'd35, 7'd2);       // split at a cylinder end
		send_request(1'b0, 2'd3, 16'd10, 7'd64);      // full count over three cylinders
		send_request(1'b1, 2'd0, 16'd100, 7'd127);    // oversized count, clamp
		send_request(1'b0, 2'd2, 16'd200, 7'd65);     // just over the clamp
		send_request(1'b1, 2'd3, 16'd2870, 7'd20);    // chunk, then run off the disk
		send_request(1'b0, 2'd0, 16'd2880, 7'd1);     // first sector past the end
		send_request(1'b1, 2'd1, 16'hFFFF, 7'd64);    // track saturates
		send_request(1'b0, 2'd3, 16'd2879, 7'd1);     // last sector on the disk
		send_request(1'b1, 2'd0, 16'd9000, 7'd0);     // empty request, junk address
		send_request(1'b0, 2'd2, 16'h8000, 7'h7F);    // every count bit set
		wait_idle();

		// Each phase loads a geometry while idle, then runs random requests on it.
		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: set_geometry(11'd18, 11'd2, 11'd80, 11'd512);
				// Raw data with high bits that the block must drop; it keeps 63 sectors, 1 head, 255 cylinders.
				1: set_geometry(11'h7FF, 11'h401, 11'h7FF, 11'd1024);
				// One sector per cylinder: requests of several sectors split at every sector.
				2: set_geometry(11'd1, 11'd1, 11'd255, 11'd128);
				3: set_geometry(11'd0, 11'd2, 11'd80, 11'd512);    // zero sectors per track
				4: set_geometry(11'd9, 11'd0, 11'd80, 11'd512);    // zero heads
				5: set_geometry(11'd17, 11'd3, 11'd40, 11'h7FF);   // three heads, widest size
				6: set_geometry(11'd5, 11'd1, 11'd0, 11'd0);       // no cylinders at all
				default: begin
					write_reg(CFG_UNMAPPED, 11'($urandom_range(0, 2047)));
					set_geometry(11'($urandom_range(0, 2047)), 11'($urandom_range(0, 2047)),
						11'($urandom_range(0, 2047)), 11'($urandom_range(0, 2047)));
				end
			endcase
			repeat (PHASE_ITEMS) random_request();
			wait_idle();
		end

		if (mismatches == 0 && pending == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

[files.f]
sv/fcts_pkg.sv
sv/floppy_chs_transfer_splitter.sv
tb/fcts_result_monitor.sv
tb/tb.sv
